[rtl/fixed_step_catchup_scheduler_core_defines.svh]
// assertion macros used by the checker file
`ifndef FIXED_STEP_CATCHUP_SCHEDULER_CORE_DEFINES_SVH
`define FIXED_STEP_CATCHUP_SCHEDULER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define FSCS_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fscs check failed");

// next-cycle implication, sampled on clock, off during reset
`define FSCS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fscs check failed");

`endif

[rtl/fscs_pkg.sv]
// ----------------------------------------------------------------------------
// fscs_pkg
// shared widths, codes and types of the catch-up scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fscs_pkg;

   localparam int ELAPSED_W  = 32;
   localparam int DUE_W      = 4;
   localparam int ACC_OUT_W  = 32;
   localparam int IVL_W      = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] REG_INTERVAL = 1'b0;
   localparam logic [IVL_W-1:0]     IVL_RESET    = 32'd1000;

   localparam logic MODE_ADVANCE = 1'b0;
   localparam logic MODE_CLEAR   = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

[rtl/fscs_div.sv]
// ----------------------------------------------------------------------------
// fscs_div
// restoring divider, one quotient bit per cycle, saturating quotient
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fscs_div #(
   parameter int DVD_W = 33,
   parameter int DVS_W = 32,
   parameter int QMAX  = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [DVD_W-1:0]                      dividend,
   input  logic [DVS_W-1:0]                      divisor,
   output fscs_pkg::div_status_type              status,
   output logic [DVS_W-1:0]                      remainder,
   output logic [$clog2(QMAX+1)-1:0]             quot_sat
);
   import fscs_pkg::*;

   localparam int QW    = $clog2(QMAX + 1);
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [QW-1:0]    q_ff, q_in;

   logic [DVS_W:0]   rem_sh;
   logic [DVS_W:0]   diff;
   logic             ge;
   logic [QW:0]      q2;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[DVD_W-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      ge      = (rem_sh >= {1'b0, dvs_ff});
      q2      = {q_ff, ge};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         q_in    = '0;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         rem_in = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
         q_in   = (q2 >= (QW+1)'(QMAX)) ? QW'(QMAX) : q2[QW-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;
   assign quot_sat    = q_ff;

endmodule

`default_nettype wire

[rtl/fixed_step_catchup_scheduler_core.sv]
// ----------------------------------------------------------------------------
// fixed_step_catchup_scheduler_core
// fixed-timestep tick accumulator with capped catch-up count
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  req     | in        | req_valid / req_ready   | mode, elapsed_ticks
//  rsp     | out       | rsp_valid / rsp_ready   | generations_due, accumulated_after,
//          |           |                         | catchup_capped
//  csr     | in        | csr_psel / csr_penable  | interval_ticks at byte address 0
//
//  clear and zero-elapsed items: result set in hold registers, then output register
//  advance items: result from the bit-serial divider, then hold and output registers
//  reset (synchronous) clears the accumulator and sets the interval to 1000
//  req_ready is low from a transfer until its result moves to the output register
//  a stalled result holds in the output register while the next item runs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fixed_step_catchup_scheduler_core #(
   parameter int MAX_CATCHUP = 8,
   parameter int TICK_BITS   = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_mode,
   input  logic [fscs_pkg::ELAPSED_W-1:0]       req_elapsed_ticks,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [fscs_pkg::DUE_W-1:0]           rsp_generations_due,
   output logic [fscs_pkg::ACC_OUT_W-1:0]       rsp_accumulated_after,
   output logic                                 rsp_catchup_capped,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fscs_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [fscs_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [fscs_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import fscs_pkg::*;

   localparam int AW = TICK_BITS + 1;
   localparam int QW = $clog2(MAX_CATCHUP + 1);
   localparam int WW = (AW > IVL_W) ? AW : IVL_W;
   localparam int OW = (AW > ACC_OUT_W) ? AW : ACC_OUT_W;
   localparam int CW = (QW > DUE_W) ? QW : DUE_W;
   localparam int EW = (TICK_BITS > ELAPSED_W) ? TICK_BITS : ELAPSED_W;
   localparam logic [IVL_W-1:0] IVL_MASK = (TICK_BITS >= IVL_W) ? '1 :
      IVL_W'((64'(1) << TICK_BITS) - 64'(1));

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_HOLD
   } state_type;

   state_type             state_ff, state_in;
   logic [AW-1:0]         acc_ff, acc_in;
   logic [IVL_W-1:0]      ivl_ff, ivl_in;
   logic [QW-1:0]         res_due_ff, res_due_in;
   logic [AW-1:0]         res_acc_ff, res_acc_in;
   logic                  res_cap_ff, res_cap_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DUE_W-1:0]      rsp_due_ff, rsp_due_in;
   logic [ACC_OUT_W-1:0]  rsp_acc_ff, rsp_acc_in;
   logic                  rsp_cap_ff, rsp_cap_in;

   logic                  csr_wr;
   logic [CSR_IDX_W-1:0]  csr_idx;
   logic [IVL_W-1:0]      wdata_m;
   logic [EW-1:0]         elapsed_ext;
   logic [TICK_BITS-1:0]  elapsed_tb;
   logic [AW-1:0]         acc_sum;
   logic                  div_start;
   div_status_type        div_stat;
   logic [IVL_W-1:0]      div_rem;
   logic [QW-1:0]         div_quot;
   logic [WW-1:0]         rem_wide;
   logic [AW-1:0]         rem_acc;
   logic [CW-1:0]         due_wide;
   logic [OW-1:0]         acc_wide;

   assign csr_pready  = 1'b1;
   assign csr_wr      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx     = csr_paddr[CSR_ADDR_W-1:2];
   assign wdata_m     = csr_pwdata & IVL_MASK;
   assign csr_prdata  = (csr_idx == REG_INTERVAL) ? ivl_ff : '0;

   assign elapsed_ext = EW'(req_elapsed_ticks);
   assign elapsed_tb  = elapsed_ext[TICK_BITS-1:0];
   assign acc_sum     = acc_ff + AW'(elapsed_tb);
   assign rem_wide    = WW'(div_rem);
   assign rem_acc     = rem_wide[AW-1:0];
   assign due_wide    = CW'(res_due_ff);
   assign acc_wide    = OW'(res_acc_ff);

   fscs_div #(
      .DVD_W (AW),
      .DVS_W (IVL_W),
      .QMAX  (MAX_CATCHUP)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (acc_sum),
      .divisor   (ivl_ff),
      .status    (div_stat),
      .remainder (div_rem),
      .quot_sat  (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      ivl_in       = ivl_ff;
      res_due_in   = res_due_ff;
      res_acc_in   = res_acc_ff;
      res_cap_in   = res_cap_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_due_in   = rsp_due_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_cap_in   = rsp_cap_ff;
      div_start    = 1'b0;
      if (csr_wr && (csr_idx == REG_INTERVAL) && (wdata_m != '0)) begin
         ivl_in = wdata_m;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_CLEAR) begin
                  acc_in     = '0;
                  res_due_in = '0;
                  res_acc_in = '0;
                  res_cap_in = 1'b0;
                  state_in   = ST_HOLD;
               end else if (elapsed_tb == '0) begin
                  res_due_in = '0;
                  res_acc_in = acc_ff;
                  res_cap_in = 1'b0;
                  state_in   = ST_HOLD;
               end else begin
                  acc_in    = acc_sum;
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               acc_in     = rem_acc;
               res_acc_in = rem_acc;
               res_due_in = div_quot;
               res_cap_in = (div_quot == QW'(MAX_CATCHUP));
               state_in   = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_due_in   = due_wide[DUE_W-1:0];
               rsp_acc_in   = acc_wide[ACC_OUT_W-1:0];
               rsp_cap_in   = res_cap_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         ivl_ff       <= IVL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         ivl_ff       <= ivl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_due_ff <= res_due_in;
      res_acc_ff <= res_acc_in;
      res_cap_ff <= res_cap_in;
      rsp_due_ff <= rsp_due_in;
      rsp_acc_ff <= rsp_acc_in;
      rsp_cap_ff <= rsp_cap_in;
   end

   assign req_ready             = (state_ff == ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_generations_due   = rsp_due_ff;
   assign rsp_accumulated_after = rsp_acc_ff;
   assign rsp_catchup_capped    = rsp_cap_ff;

endmodule

`default_nettype wire

[rtl/fscs_checker.sv]
// ----------------------------------------------------------------------------
// fscs_checker
// port-level checks of the catch-up scheduler, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fixed_step_catchup_scheduler_core_defines.svh"

module fscs_checker #(
   parameter int MAX_CATCHUP = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [fscs_pkg::DUE_W-1:0]         rsp_generations_due,
   input  logic [fscs_pkg::ACC_OUT_W-1:0]     rsp_accumulated_after,
   input  logic                               rsp_catchup_capped
);
   import fscs_pkg::*;

   // a stalled result keeps its payload
   `FSCS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_generations_due) && $stable(rsp_accumulated_after) && $stable(rsp_catchup_capped))

   // one item at a time: no transfer right after a transfer
   `FSCS_ASSERT_NEXT(a_req_busy, req_valid && req_ready, !req_ready)

   // a capped result reports the full catch-up count
   `FSCS_ASSERT_SAME(a_cap_count, rsp_valid && rsp_catchup_capped, rsp_generations_due == DUE_W'(MAX_CATCHUP))

   // the count never exceeds the limit, checked while the limit fits in DUE_W bits
   `FSCS_ASSERT_SAME(a_count_max, rsp_valid, (MAX_CATCHUP > 15) || (32'(rsp_generations_due) <= 32'(MAX_CATCHUP)))

endmodule

bind fixed_step_catchup_scheduler_core fscs_checker #(
   .MAX_CATCHUP (MAX_CATCHUP)
) u_fscs_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_ready             (req_ready),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_generations_due   (rsp_generations_due),
   .rsp_accumulated_after (rsp_accumulated_after),
   .rsp_catchup_capped    (rsp_catchup_capped)
);

`default_nettype wire

[sim/fixed_step_catchup_scheduler_core_test.sv]
// ----------------------------------------------------------------------------
// fixed_step_catchup_scheduler_core_test
// self-checking bench for the capped catch-up tick scheduler
// ----------------------------------------------------------------------------
// A queue of tick reports feeds a valid/ready driver while a monitor keeps a
// cycle-free copy of the accumulator and interval register, predicts each
// result at the input transfer and checks it against the output transfer.
// Directed reports hit the cap boundary, full-scale elapsed and clears, then
// random phases run at several interval settings from 1 to 2^32-1 with random
// gaps on both channels, a long output hold-off and idle-only CSR writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_step_catchup_scheduler_core_test;

   import fscs_pkg::*;

   localparam int CATCHUP_LIMIT  = 8;
   localparam int TICK_W         = 32;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int END_SETTLE     = 60;

   localparam logic [CSR_ADDR_W-1:0] ADDR_INTERVAL = {REG_INTERVAL, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNUSED   = ADDR_INTERVAL + 3'd4;

   typedef struct packed {
      logic                 mode;
      logic [ELAPSED_W-1:0] elapsed;
   } tick_report_type;

   typedef struct packed {
      logic [DUE_W-1:0]     due;
      logic [ACC_OUT_W-1:0] acc;
      logic                 capped;
   } catchup_result_type;

   logic                  clock                 = 1'b0;
   logic                  reset                 = 1'b1;
   logic                  req_valid             = 1'b0;
   logic                  req_ready;
   logic                  req_mode              = MODE_ADVANCE;
   logic [ELAPSED_W-1:0]  req_elapsed_ticks     = '0;
   logic                  rsp_valid;
   logic                  rsp_ready             = 1'b0;
   logic [DUE_W-1:0]      rsp_generations_due;
   logic [ACC_OUT_W-1:0]  rsp_accumulated_after;
   logic                  rsp_catchup_capped;
   logic                  csr_psel              = 1'b0;
   logic                  csr_penable           = 1'b0;
   logic                  csr_pwrite            = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr             = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata            = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   tick_report_type    tick_reports[$];
   catchup_result_type catchup_results[$];

   logic [TICK_W:0]    acc_ticks      = '0;
   logic [IVL_W-1:0]   interval_ticks = IVL_RESET;

   logic req_fire      = 1'b0;
   bit   send_idle_en  = 1'b1;
   bit   recv_idle_en  = 1'b1;
   int   send_gap      = 0;
   int   stall_left    = 0;
   int   hold_left     = 0;
   int   hold_requests = 0;
   int   hold_served   = 0;
   int   idle_cycles   = 0;
   int   n_fail        = 0;
   int   n_reports     = 0;
   int   n_clears      = 0;
   int   n_zero        = 0;
   int   n_results     = 0;
   int   n_capped      = 0;
   int   n_csr_writes  = 0;

   fixed_step_catchup_scheduler_core #(
      .MAX_CATCHUP(CATCHUP_LIMIT),
      .TICK_BITS  (TICK_W)
   ) i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_elapsed_ticks    (req_elapsed_ticks),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_generations_due  (rsp_generations_due),
      .rsp_accumulated_after(rsp_accumulated_after),
      .rsp_catchup_capped   (rsp_catchup_capped),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   always #2 clock = ~clock;

   function automatic catchup_result_type step_scheduler(input tick_report_type rep);
      catchup_result_type res;
      logic [63:0]        sum;
      logic [63:0]        due;
      res = '0;
      if (rep.mode == MODE_CLEAR) begin
         acc_ticks = '0;
      end else if (rep.elapsed != '0) begin
         sum = 64'(acc_ticks) + 64'(rep.elapsed);
         sum = sum & ((64'd1 << (TICK_W + 1)) - 64'd1);
         due = sum / 64'(interval_ticks);
         if (due >= 64'(CATCHUP_LIMIT)) begin
            acc_ticks   = (TICK_W + 1)'(sum % 64'(interval_ticks));
            res.due     = DUE_W'(CATCHUP_LIMIT);
            res.capped  = 1'b1;
         end else begin
            acc_ticks = (TICK_W + 1)'(sum - due * 64'(interval_ticks));
            res.due   = DUE_W'(due);
         end
      end
      res.acc = acc_ticks[ACC_OUT_W-1:0];
      return res;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int idle_len(input bit enable);
      int unsigned pick;
      pick = $urandom_range(99);
      if (!enable || pick < 50)
         return 0;
      else if (pick < 88)
         return $urandom_range(1, 3);
      else if (pick < 97)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   function automatic tick_report_type random_report();
      tick_report_type rep;
      int unsigned     pick;
      logic [63:0]     span;
      pick        = $urandom_range(99);
      rep.mode    = MODE_ADVANCE;
      rep.elapsed = '0;
      if (pick < 8) begin
         rep.mode    = MODE_CLEAR;
         rep.elapsed = $urandom;
      end else if (pick < 16) begin
         rep.elapsed = '0;
      end else if (pick < 36) begin
         rep.elapsed = $urandom;
      end else if (pick < 72) begin
         // land around the cap boundary
         span = 64'(interval_ticks) * 64'($urandom_range(0, 10))
              + 64'($urandom_range(interval_ticks - 1));
         rep.elapsed = (span[63:32] != '0) ? ELAPSED_W'($urandom) : span[31:0];
      end else begin
         rep.elapsed = $urandom_range(interval_ticks);
      end
      return rep;
   endfunction

   task automatic offer(input logic mode, input logic [ELAPSED_W-1:0] elapsed);
      tick_report_type rep;
      rep.mode    = mode;
      rep.elapsed = elapsed;
      tick_reports.push_back(rep);
   endtask

   task automatic wait_idle();
      do
         @(posedge clock);
      while (tick_reports.size() != 0 || req_valid || catchup_results.size() != 0);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      if (addr == ADDR_INTERVAL && data != '0)
         interval_ticks = data;
      n_csr_writes++;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_read_interval();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_INTERVAL;
      @(negedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      if (csr_prdata !== interval_ticks) begin
         $error("interval_ticks readback: expected %0d, actual %0d",
                interval_ticks, csr_prdata);
         n_fail++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic run_phase(input logic [IVL_W-1:0] ivl, input int count,
                            input bit send_idle, input bit recv_idle, input bit long_hold);
      wait_idle();
      csr_write(ADDR_INTERVAL, ivl);
      csr_read_interval();
      send_idle_en = send_idle;
      recv_idle_en = recv_idle;
      if (long_hold)
         hold_requests++;
      repeat (count) tick_reports.push_back(random_report());
   endtask

   // report driver
   always @(negedge clock) begin : report_driver
      tick_report_type rep;
      logic            keep_valid;
      if (!reset) begin
         keep_valid = req_valid && !req_fire;
         if (!keep_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (tick_reports.size() != 0) begin
               rep = tick_reports.pop_front();
               req_mode          <= rep.mode;
               req_elapsed_ticks <= rep.elapsed;
               keep_valid        = 1'b1;
               send_gap          = idle_len(send_idle_en);
            end
         end
         req_valid <= keep_valid;
      end
   end

   // result receiver
   always @(negedge clock) begin : result_receiver
      logic ready_next;
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         ready_next = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         ready_next = 1'b0;
      end else begin
         ready_next = 1'b1;
         if (recv_idle_en && $urandom_range(7) == 0)
            stall_left = idle_len(1'b1);
      end
      rsp_ready <= reset ? 1'b0 : ready_next;
   end

   // transfer monitor and result check
   always @(posedge clock) begin : result_monitor
      tick_report_type    rep;
      catchup_result_type want;
      bit                 moved;
      if (reset) begin
         req_fire    <= 1'b0;
         idle_cycles = 0;
      end else begin
         moved    = 1'b0;
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            moved       = 1'b1;
            rep.mode    = req_mode;
            rep.elapsed = req_elapsed_ticks;
            catchup_results.push_back(step_scheduler(rep));
            n_reports++;
            if (rep.mode == MODE_CLEAR)
               n_clears++;
            else if (rep.elapsed == '0)
               n_zero++;
         end
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            if (catchup_results.size() == 0) begin
               $error("result transfer with nothing outstanding: due %0d acc %0d capped %0d",
                      rsp_generations_due, rsp_accumulated_after, rsp_catchup_capped);
               n_fail++;
            end else begin
               want = catchup_results.pop_front();
               n_results++;
               if (want.capped)
                  n_capped++;
               if (rsp_generations_due !== want.due) begin
                  $error("generations_due: expected %0d, actual %0d",
                         want.due, rsp_generations_due);
                  n_fail++;
               end
               if (rsp_accumulated_after !== want.acc) begin
                  $error("accumulated_after: expected %0d, actual %0d",
                         want.acc, rsp_accumulated_after);
                  n_fail++;
               end
               if (rsp_catchup_capped !== want.capped) begin
                  $error("catchup_capped: expected %0d, actual %0d",
                         want.capped, rsp_catchup_capped);
                  n_fail++;
               end
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, catchup_results.size());
            $display("FAIL fixed_step_catchup_scheduler_core");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      csr_read_interval();

      // directed reports at the reset interval
      offer(MODE_CLEAR,   32'hFFFF_FFFF);
      offer(MODE_ADVANCE, 32'd0);
      offer(MODE_ADVANCE, 32'd999);
      offer(MODE_ADVANCE, 32'd0);
      offer(MODE_ADVANCE, 32'd1);
      offer(MODE_ADVANCE, 32'd7999);
      offer(MODE_ADVANCE, 32'd1);
      offer(MODE_ADVANCE, 32'd8000);
      offer(MODE_ADVANCE, 32'd7000);
      offer(MODE_ADVANCE, 32'hFFFF_FFFF);
      offer(MODE_ADVANCE, 32'hFFFF_FFFF);
      offer(MODE_ADVANCE, 32'h8000_0000);
      offer(MODE_ADVANCE, 32'h5555_5555);
      offer(MODE_ADVANCE, 32'hAAAA_AAAA);
      offer(MODE_CLEAR,   32'd0);
      offer(MODE_ADVANCE, 32'd1500);
      offer(MODE_ADVANCE, 32'd2500);
      offer(MODE_ADVANCE, 32'd1234);
      wait_idle();

      // zero write and unmapped address must leave the interval alone
      csr_write(ADDR_INTERVAL, '0);
      csr_write(ADDR_UNUSED, 32'd5);
      csr_read_interval();
      offer(MODE_ADVANCE, 32'd766);
      offer(MODE_ADVANCE, 32'd300);

      // each phase starts with ticks still pending from the one before
      run_phase(32'd1,              90, 1'b1, 1'b1, 1'b0);
      run_phase(32'hFFFF_FFFF,      90, 1'b1, 1'b1, 1'b0);
      run_phase(32'd3,              90, 1'b0, 1'b0, 1'b1);
      run_phase($urandom_range(2, 5000), 110, 1'b1, 1'b1, 1'b0);
      run_phase($urandom,          110, 1'b1, 1'b0, 1'b0);
      run_phase(IVL_RESET,         100, 1'b0, 1'b1, 1'b0);

      wait_idle();
      repeat (END_SETTLE) @(posedge clock);
      $display("covered %0d reports (%0d clears, %0d zero-elapsed), %0d results, %0d capped",
               n_reports, n_clears, n_zero, n_results, n_capped);
      $display("%0d interval writes incl. zero and unmapped address, intervals 1 to 2^32-1",
               n_csr_writes);
      if (n_fail == 0)
         $display("PASS fixed_step_catchup_scheduler_core");
      else
         $display("FAIL fixed_step_catchup_scheduler_core");
      $finish;
   end

endmodule
